### src/spx_pkg.sv
// Package for the segment/sphere proximity pipeline: result codes, opcodes,
// register map and pipeline depth. Used by every module of the block.
// No dependencies.
package spx_pkg;

  // Default coordinate width and the fixed tolerance register width.
  localparam int COORD_BITS_DFLT = 16;
  localparam int TOL_BITS        = 20;
  localparam int APB_DW          = 32;

  // Register stages from input word to output word.
  localparam int STAGES = 8;

  // Opcodes carried in tuser.
  localparam logic OP_POINT   = 1'b0;
  localparam logic OP_SEGMENT = 1'b1;

  // Relation codes.
  localparam logic [1:0] REL_INSIDE  = 2'd0;
  localparam logic [1:0] REL_ON      = 2'd1;
  localparam logic [1:0] REL_OUTSIDE = 2'd2;

  // Nearest feature codes.
  localparam logic [1:0] FEAT_END_A    = 2'd0;
  localparam logic [1:0] FEAT_END_B    = 2'd1;
  localparam logic [1:0] FEAT_INTERIOR = 2'd2;

  // Register index as decoded from paddr[2].
  localparam logic REG_TOLERANCE = 1'b0;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### src/spx_geom.sv
// Front of the pipeline (stages 1 to 4): differences, products, dot and cross
// sums, and nearest feature selection. Depends on spx_pkg.
module spx_geom import spx_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DFLT
) (
  input  logic                      clk,
  input  logic [3:0]                load,
  input  logic                      opcode,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] cz,
  input  logic [COORD_BITS-2:0]     radius,
  output logic [1:0]                feat,
  output logic [2*COORD_BITS:0]     kmag [3],
  output logic [2*COORD_BITS+1:0]   pdist,
  output logic [2*COORD_BITS+1:0]   scale,
  output logic [2*COORD_BITS-3:0]   r2
);

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;       // coordinate difference
  localparam int PW  = 2 * C + 2;   // product of two differences
  localparam int SW  = 2 * C + 4;   // sum of three products
  localparam int KSW = 2 * C + 3;   // cross product component
  localparam int KW  = 2 * C + 1;   // its magnitude
  localparam int DDW = 2 * C + 2;   // squared length
  localparam int R2W = 2 * C - 2;   // squared radius

  // Stage 1: differences.
  logic signed [DW-1:0] d [3];
  logic signed [DW-1:0] w [3];
  logic signed [DW-1:0] v [3];
  logic                 op1;
  logic [C-2:0]         r1;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      d[0] <= DW'(bx) - DW'(ax);
      d[1] <= DW'(by) - DW'(ay);
      d[2] <= DW'(bz) - DW'(az);
      w[0] <= DW'(cx) - DW'(ax);
      w[1] <= DW'(cy) - DW'(ay);
      w[2] <= DW'(cz) - DW'(az);
      v[0] <= DW'(cx) - DW'(bx);
      v[1] <= DW'(cy) - DW'(by);
      v[2] <= DW'(cz) - DW'(bz);
      op1  <= opcode;
      r1   <= radius;
    end
  end

  // Stage 2: all pairwise products, one multiplier each.
  logic signed [PW-1:0] dw [3];
  logic signed [PW-1:0] dv [3];
  logic signed [PW-1:0] cp [3];
  logic signed [PW-1:0] cn [3];
  logic [PW-1:0]        ddsq [3];
  logic [PW-1:0]        wwsq [3];
  logic [PW-1:0]        vvsq [3];
  logic                 point2;
  logic [R2W-1:0]       r2_2;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      for (int i = 0; i < 3; i++) begin
        dw[i]   <= PW'(d[i]) * PW'(w[i]);
        dv[i]   <= PW'(d[i]) * PW'(v[i]);
        ddsq[i] <= PW'(PW'(d[i]) * PW'(d[i]));
        wwsq[i] <= PW'(PW'(w[i]) * PW'(w[i]));
        vvsq[i] <= PW'(PW'(v[i]) * PW'(v[i]));
      end
      cp[0] <= PW'(d[1]) * PW'(w[2]);
      cn[0] <= PW'(w[1]) * PW'(d[2]);
      cp[1] <= PW'(d[2]) * PW'(w[0]);
      cn[1] <= PW'(w[2]) * PW'(d[0]);
      cp[2] <= PW'(d[0]) * PW'(w[1]);
      cn[2] <= PW'(w[0]) * PW'(d[1]);
      // A segment whose ends coincide is handled as a point.
      point2 <= (op1 == OP_POINT) || ((d[0] == '0) && (d[1] == '0) && (d[2] == '0));
      r2_2   <= R2W'(r1) * R2W'(r1);
    end
  end

  // Stage 3: dot product signs, cross components and squared lengths.
  logic signed [SW-1:0]  dotw;
  logic signed [SW-1:0]  dotv;
  logic                  near_a3;
  logic                  near_b3;
  logic                  point3;
  logic signed [KSW-1:0] k3 [3];
  logic [DDW-1:0]        dd3;
  logic [DDW-1:0]        wsq3;
  logic [DDW-1:0]        vsq3;
  logic [R2W-1:0]        r2_3;

  always_comb begin
    dotw = SW'(dw[0]) + SW'(dw[1]) + SW'(dw[2]);
    dotv = SW'(dv[0]) + SW'(dv[1]) + SW'(dv[2]);
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      // End a is nearest when (b-a).(c-a) is negative; end b when
      // (a-b).(c-b) is negative, i.e. (b-a).(c-b) is positive.
      near_a3 <= dotw[SW-1];
      near_b3 <= !dotv[SW-1] && (dotv != '0);
      point3  <= point2;
      for (int i = 0; i < 3; i++) begin
        k3[i] <= KSW'(cp[i]) - KSW'(cn[i]);
      end
      dd3  <= DDW'(ddsq[0]) + DDW'(ddsq[1]) + DDW'(ddsq[2]);
      wsq3 <= DDW'(wwsq[0]) + DDW'(wwsq[1]) + DDW'(wwsq[2]);
      vsq3 <= DDW'(vvsq[0]) + DDW'(vvsq[1]) + DDW'(vvsq[2]);
      r2_3 <= r2_2;
    end
  end

  // Stage 4: pick the nearest feature and its distance terms.
  always_ff @(posedge clk) begin
    if (load[3]) begin
      if (point3 || near_a3) begin
        feat  <= FEAT_END_A;
        pdist <= wsq3;
        scale <= DDW'(1);
      end else if (near_b3) begin
        feat  <= FEAT_END_B;
        pdist <= vsq3;
        scale <= DDW'(1);
      end else begin
        feat  <= FEAT_INTERIOR;
        pdist <= wsq3;
        scale <= dd3;
      end
      for (int i = 0; i < 3; i++) begin
        kmag[i] <= k3[i][KSW-1] ? KW'(-k3[i]) : KW'(k3[i]);
      end
      r2 <= r2_3;
    end
  end

endmodule

### src/spx_scale.sv
// Middle of the pipeline (stages 5 to 7): split multiplications for the
// squared cross product and for the scaled radius and tolerance.
// Depends on spx_pkg.
module spx_scale import spx_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DFLT
) (
  input  logic                          clk,
  input  logic [2:0]                    load,
  input  logic [TOL_BITS-1:0]           tolerance,
  input  logic [1:0]                    feat,
  input  logic [2*COORD_BITS:0]         kmag [3],
  input  logic [2*COORD_BITS+1:0]       pdist,
  input  logic [2*COORD_BITS+1:0]       scale,
  input  logic [2*COORD_BITS-3:0]       r2,
  output logic [1:0]                    feat_out,
  output logic [4*COORD_BITS+3:0]       sq_dist,
  output logic [4*COORD_BITS-1:0]       rr,
  output logic [2*COORD_BITS+TOL_BITS+1:0] tt
);

  localparam int C     = COORD_BITS;
  localparam int KW    = 2 * C + 1;
  localparam int H     = C + 1;          // low half of a cross magnitude
  localparam int HHW   = 2 * C;
  localparam int HLW   = 2 * C + 1;
  localparam int LLW   = 2 * C + 2;
  localparam int KQW   = 4 * C + 2;      // one squared cross component
  localparam int DISTW = 4 * C + 4;
  localparam int DDW   = 2 * C + 2;
  localparam int R2W   = 2 * C - 2;
  localparam int RPW   = 2 * C;          // partial of r2 * scale
  localparam int TPW   = TOL_BITS + C + 1;
  localparam int RRW   = 4 * C;
  localparam int TTW   = 2 * C + TOL_BITS + 2;

  // Stage 5: partial products, none wider than C+1 by C+1 bits but the tolerance ones, TOL_BITS by C+1 bits.
  logic [HHW-1:0] k_hh [3];
  logic [HLW-1:0] k_hl [3];
  logic [LLW-1:0] k_ll [3];
  logic [RPW-1:0] rp_ll, rp_lh, rp_hl, rp_hh;
  logic [TPW-1:0] tp_lo, tp_hi;
  logic [1:0]     feat5;
  logic [DDW-1:0] pdist5;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      for (int i = 0; i < 3; i++) begin
        k_hh[i] <= HHW'(kmag[i][KW-1:H]) * HHW'(kmag[i][KW-1:H]);
        k_hl[i] <= HLW'(kmag[i][KW-1:H]) * HLW'(kmag[i][H-1:0]);
        k_ll[i] <= LLW'(kmag[i][H-1:0]) * LLW'(kmag[i][H-1:0]);
      end
      rp_ll  <= RPW'(r2[C-2:0])     * RPW'(scale[C:0]);
      rp_lh  <= RPW'(r2[C-2:0])     * RPW'(scale[DDW-1:C+1]);
      rp_hl  <= RPW'(r2[R2W-1:C-1]) * RPW'(scale[C:0]);
      rp_hh  <= RPW'(r2[R2W-1:C-1]) * RPW'(scale[DDW-1:C+1]);
      tp_lo  <= TPW'(tolerance) * TPW'(scale[C:0]);
      tp_hi  <= TPW'(tolerance) * TPW'(scale[DDW-1:C+1]);
      feat5  <= feat;
      pdist5 <= pdist;
    end
  end

  // Stage 6: recombine the partials.
  logic [KQW-1:0] ksq6 [3];
  logic [RRW-1:0] rr6;
  logic [TTW-1:0] tt6;
  logic [1:0]     feat6;
  logic [DDW-1:0] pdist6;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      for (int i = 0; i < 3; i++) begin
        ksq6[i] <= (KQW'(k_hh[i]) << (2 * H)) + (KQW'(k_hl[i]) << (H + 1)) +
                   KQW'(k_ll[i]);
      end
      rr6 <= RRW'(rp_ll) + (RRW'(rp_lh) << (C + 1)) + (RRW'(rp_hl) << (C - 1)) +
             (RRW'(rp_hh) << (2 * C));
      tt6    <= TTW'(tp_lo) + (TTW'(tp_hi) << (C + 1));
      feat6  <= feat5;
      pdist6 <= pdist5;
    end
  end

  // Stage 7: squared distance, scaled by the squared length for the interior.
  always_ff @(posedge clk) begin
    if (load[2]) begin
      if (feat6 == FEAT_INTERIOR) begin
        sq_dist <= DISTW'(ksq6[0]) + DISTW'(ksq6[1]) + DISTW'(ksq6[2]);
      end else begin
        sq_dist <= DISTW'(pdist6);
      end
      rr       <= rr6;
      tt       <= tt6;
      feat_out <= feat6;
    end
  end

endmodule

### src/spx_classify.sv
// Last stage: compares the squared distance against the squared radius with
// the tolerance band and holds the output word. Depends on spx_pkg.
module spx_classify import spx_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DFLT
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic [1:0]                        feat,
  input  logic [4*COORD_BITS+3:0]           sq_dist,
  input  logic [4*COORD_BITS-1:0]           rr,
  input  logic [2*COORD_BITS+TOL_BITS+1:0]  tt,
  output logic [1:0]                        relation,
  output logic [1:0]                        nearest_feature
);

  localparam int C    = COORD_BITS;
  localparam int CMPW = max_int(4 * C + 4, 2 * C + TOL_BITS + 2) + 1;

  logic below;
  logic above;

  // Two add-and-compare paths side by side.
  always_comb begin
    below = (CMPW'(sq_dist) + CMPW'(tt)) < CMPW'(rr);
    above = (CMPW'(rr) + CMPW'(tt)) < CMPW'(sq_dist);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (below) begin
        relation <= REL_INSIDE;
      end else if (above) begin
        relation <= REL_OUTSIDE;
      end else begin
        relation <= REL_ON;
      end
      nearest_feature <= feat;
    end
  end

endmodule

### src/segment_sphere_proximity_test.sv
// Top level of the segment/sphere proximity test: stream ports, APB
// tolerance register and the pipeline valid chain.
// Depends on spx_pkg, spx_geom, spx_scale and spx_classify.
//
//   Channel   Dir  Fields
//   s_*       in   tuser: opcode; tdata: first, second, center xyz, radius
//   m_*       out  tdata: relation, nearest_feature
//   APB       in   tolerance register at byte address 0
//
// Eight register stages; one word can enter in every cycle while the output
// is not stalled. Each stage loads when it is empty or the stage after it
// moves, so bubbles are filled while the output is stalled, and a stall
// never drops a word. Reset clears the valid chain and the tolerance
// register to zero.
module segment_sphere_proximity_test import spx_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DFLT,
  localparam int TDATA_W   = ((10 * COORD_BITS - 1 + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  // Input stream.
  input  logic               s_tvalid,
  output logic               s_tready,
  // tdata from bit 0: first_x, first_y, first_z, second_x, second_y,
  // second_z, center_x, center_y, center_z, radius, zero fill.
  input  logic [TDATA_W-1:0] s_tdata,
  // tuser: opcode.
  input  logic               s_tuser,
  // Output stream.
  output logic               m_tvalid,
  input  logic               m_tready,
  // tdata from bit 0: relation (2), nearest_feature (2), zero fill.
  output logic [7:0]         m_tdata,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int C = COORD_BITS;

  // Tolerance register.
  logic [TOL_BITS-1:0] tolerance;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOLERANCE)) begin
      tolerance <= pwdata[TOL_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TOLERANCE) ? APB_DW'(tolerance) : '0;

  // Valid chain and per-stage load enables.
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] load;

  always_comb begin
    load[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (load[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_tready = load[0];
  assign m_tvalid = vld[STAGES-1];

  // Datapath.
  logic [1:0]             feat4;
  logic [2*C:0]           kmag4 [3];
  logic [2*C+1:0]         pdist4;
  logic [2*C+1:0]         scale4;
  logic [2*C-3:0]         r2_4;
  logic [1:0]             feat7;
  logic [4*C+3:0]         dist7;
  logic [4*C-1:0]         rr7;
  logic [2*C+TOL_BITS+1:0] tt7;
  logic [1:0]             relation;
  logic [1:0]             nearest_feature;

  spx_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk    (clk),
    .load   (load[3:0]),
    .opcode (s_tuser),
    .ax     (s_tdata[0*C +: C]),
    .ay     (s_tdata[1*C +: C]),
    .az     (s_tdata[2*C +: C]),
    .bx     (s_tdata[3*C +: C]),
    .by     (s_tdata[4*C +: C]),
    .bz     (s_tdata[5*C +: C]),
    .cx     (s_tdata[6*C +: C]),
    .cy     (s_tdata[7*C +: C]),
    .cz     (s_tdata[8*C +: C]),
    .radius (s_tdata[9*C +: C-1]),
    .feat   (feat4),
    .kmag   (kmag4),
    .pdist  (pdist4),
    .scale  (scale4),
    .r2     (r2_4)
  );

  spx_scale #(.COORD_BITS(COORD_BITS)) u_scale (
    .clk       (clk),
    .load      (load[6:4]),
    .tolerance (tolerance),
    .feat      (feat4),
    .kmag      (kmag4),
    .pdist     (pdist4),
    .scale     (scale4),
    .r2        (r2_4),
    .feat_out  (feat7),
    .sq_dist   (dist7),
    .rr        (rr7),
    .tt        (tt7)
  );

  spx_classify #(.COORD_BITS(COORD_BITS)) u_classify (
    .clk             (clk),
    .load            (load[7]),
    .feat            (feat7),
    .sq_dist         (dist7),
    .rr              (rr7),
    .tt              (tt7),
    .relation        (relation),
    .nearest_feature (nearest_feature)
  );

  assign m_tdata = {4'b0000, nearest_feature, relation};

endmodule

### src/spx_checker.sv
// Port-level checks for the proximity test top level, attached by bind.
// Depends on spx_pkg and segment_sphere_proximity_test.
module spx_checker import spx_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [7:0]        m_tdata,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [2:0]        paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata
);

  // A stalled output word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Only defined relation and feature codes leave the block.
  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == REL_INSIDE || m_tdata[1:0] == REL_ON ||
                  m_tdata[1:0] == REL_OUTSIDE) &&
                 (m_tdata[3:2] == FEAT_END_A || m_tdata[3:2] == FEAT_END_B ||
                  m_tdata[3:2] == FEAT_INTERIOR))
    else $error("undefined result code");

  // A tolerance write reads back on the next cycle.
  a_tol_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == REG_TOLERANCE) |=>
      (paddr[2] != REG_TOLERANCE) ||
      (prdata == {{(APB_DW-TOL_BITS){1'b0}}, $past(pwdata[TOL_BITS-1:0])}))
    else $error("tolerance register readback mismatch");

endmodule

bind segment_sphere_proximity_test spx_checker u_spx_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);
